/* rtl/oal_pkg.sv */
// Shared constants, codes and types for the ordered array list engine.
// No dependencies; every module in rtl/ imports this package.
package oal_pkg;

  localparam int CAPACITY = 256;

  localparam int OP_W     = 2;
  localparam int INDEX_W  = 9;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 8;
  localparam int COUNT_W  = 9;

  // internal count holds 0..CAPACITY; compares run at the wider of count and index
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  // find scans the hit vector one group per cycle, holding while the result register is full
  localparam int GROUP_W = 16;
  localparam int GSEL_W  = $clog2(GROUP_W);
  localparam int NGROUPS = (CAPACITY + GROUP_W - 1) / GROUP_W;
  localparam int GIDX_W  = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
  localparam int HIT_W   = NGROUPS * GROUP_W;

  localparam int IN_BITS     = OP_W + INDEX_W + VALUE_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = STATUS_W + POS_W + COUNT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2,
    OP_MODIFY = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  // broadcast to every cell
  typedef struct packed {
    logic               ins;
    logic               del;
    logic               mod;
    logic               cmp;
    logic [CMP_W-1:0]   idx;
    logic [VALUE_W-1:0] value;
  } cell_cmd_t;

  // scanner view of the current group
  typedef struct packed {
    logic             hit;
    logic             last;
    logic [POS_W-1:0] pos;
  } scan_res_t;

endpackage

/* rtl/oal_cell.sv */
// One list slot: holds an entry, shifts with its neighbors, compares for find.
// Depends on oal_pkg.
module oal_cell (
  input  logic                         clk,
  input  oal_pkg::cell_cmd_t           cmd,
  input  logic [oal_pkg::CMP_W-1:0]    slot,   // this cell's list position
  input  logic [oal_pkg::CMP_W-1:0]    count,
  input  logic [oal_pkg::VALUE_W-1:0]  left,   // entry of slot-1
  input  logic [oal_pkg::VALUE_W-1:0]  right,  // entry of slot+1
  output logic [oal_pkg::VALUE_W-1:0]  data,
  output logic                         hit
);
  import oal_pkg::*;

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (slot > cmd.idx) begin
        data <= left;
      end else if (slot == cmd.idx) begin
        data <= cmd.value;
      end
    end else if (cmd.del) begin
      if (slot >= cmd.idx) begin
        data <= right;
      end
    end else if (cmd.mod && (slot == cmd.idx)) begin
      data <= cmd.value;
    end

    if (cmd.cmp) begin
      hit <= (data == cmd.value) && (slot < count);
    end
  end

endmodule

/* rtl/oal_scan.sv */
// Find scanner: steps a group pointer over the cell hit flags and
// priority-encodes the lowest hit in the current group. Depends on oal_pkg.
module oal_scan (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clear,
  input  logic                        step,
  input  logic [oal_pkg::HIT_W-1:0]   hits,
  output oal_pkg::scan_res_t          res
);
  import oal_pkg::*;

  logic [GIDX_W-1:0]  grp;
  logic [GROUP_W-1:0] bits;
  logic [GSEL_W-1:0]  sel;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      grp <= '0;
    end else if (step) begin
      grp <= grp + 1'b1;
    end
  end

  always_comb begin
    bits = hits[{grp, GSEL_W'(0)} +: GROUP_W];
    sel  = '0;
    for (int i = GROUP_W - 1; i >= 0; i--) begin
      if (bits[i]) begin
        sel = GSEL_W'(i);
      end
    end
    res.hit  = |bits;
    res.last = (grp == GIDX_W'(NGROUPS - 1));
    res.pos  = POS_W'({grp, sel});
  end

endmodule

/* rtl/ordered_array_list_engine_core.sv */
// Ordered array list engine, top level: input decode, control FSM,
// cell chain, find scanner and result register. Depends on oal_pkg,
// oal_cell and oal_scan.
//
// The list lives in a row of CAPACITY cells, one entry per cell; each cell
// loads from its left or right neighbor so insert and delete shift the whole
// list together. Insert, delete and modify finish in the cycle they are
// accepted, so such requests go through at one per cycle while the result
// register is free or being drained. For find, every cell compares in the
// accept cycle, then the scanner walks the hit flags 16 cells per cycle,
// holding while the result register is full, and stops at the first group
// with a hit. The result sits in an output register, so the next request is
// taken while an earlier result waits, as long as the register is free or
// being drained that same cycle. The entries are not cleared by reset; only
// the count and control state are, and nothing below the count is left unwritten.
module ordered_array_list_engine_core (
  input  logic                              clk,
  input  logic                              rst,
  // request: [1:0] operation, [10:2] index, [42:11] value, rest zero
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [oal_pkg::IN_TDATA_W-1:0]    s_tdata,
  // result: [1:0] status, [9:2] position, [18:10] count, rest zero
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [oal_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import oal_pkg::*;

  // request fields
  op_t                in_op;
  logic [INDEX_W-1:0] in_index;
  logic [VALUE_W-1:0] in_value;
  logic [CMP_W-1:0]   idx_ext;
  logic [CMP_W-1:0]   cnt_ext;

  state_t state, state_next;

  logic [CNT_W-1:0]    entry_count, entry_count_next;
  logic                accept;
  logic                slot_free;

  // result register
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [POS_W-1:0]    res_pos, res_pos_next;
  logic [CNT_W-1:0]    res_count;
  logic                res_load;

  logic                scan_clear, scan_step;
  scan_res_t           scan;
  cell_cmd_t           cmd;

  logic [VALUE_W-1:0]  cell_data [CAPACITY];
  logic [HIT_W-1:0]    hits;

  assign in_op    = op_t'(s_tdata[OP_W-1:0]);
  assign in_index = s_tdata[OP_W +: INDEX_W];
  assign in_value = s_tdata[OP_W + INDEX_W +: VALUE_W];
  assign idx_ext  = CMP_W'(in_index);
  assign cnt_ext  = CMP_W'(entry_count);

  assign slot_free = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (in_op == OP_FIND)) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (slot_free && (scan.hit || scan.last)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the FSM: handshake, cell command, scanner and result load
  always_comb begin
    s_tready         = 1'b0;
    scan_clear       = 1'b0;
    scan_step        = 1'b0;
    res_load         = 1'b0;
    res_status_next  = ST_OK;
    res_pos_next     = '0;
    entry_count_next = entry_count;
    cmd.ins          = 1'b0;
    cmd.del          = 1'b0;
    cmd.mod          = 1'b0;
    cmd.cmp          = 1'b0;
    cmd.idx          = idx_ext;
    cmd.value        = in_value;
    unique case (state)
      S_IDLE: begin
        // no request is taken while reset is held
        s_tready = slot_free && !rst;
        if (accept) begin
          unique case (in_op)
            OP_INSERT: begin
              res_load = 1'b1;
              if (idx_ext > cnt_ext) begin
                res_status_next = ST_RANGE;
              end else if (cnt_ext >= CMP_W'(CAPACITY)) begin
                res_status_next = ST_FULL;
              end else begin
                cmd.ins          = 1'b1;
                entry_count_next = entry_count + 1'b1;
              end
            end
            OP_DELETE: begin
              res_load = 1'b1;
              if (idx_ext >= cnt_ext) begin
                res_status_next = ST_RANGE;
              end else begin
                cmd.del          = 1'b1;
                entry_count_next = entry_count - 1'b1;
              end
            end
            OP_MODIFY: begin
              res_load = 1'b1;
              if (idx_ext >= cnt_ext) begin
                res_status_next = ST_RANGE;
              end else begin
                cmd.mod = 1'b1;
              end
            end
            OP_FIND: begin
              // cells latch their compare; result comes from the scan
              cmd.cmp    = 1'b1;
              scan_clear = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (slot_free) begin
          if (scan.hit) begin
            res_load     = 1'b1;
            res_pos_next = scan.pos;
          end else if (scan.last) begin
            res_load        = 1'b1;
            res_status_next = ST_MISSING;
          end else begin
            scan_step = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_status <= res_status_next;
      res_pos    <= res_pos_next;
      res_count  <= entry_count_next;
    end
  end

  assign m_tdata = OUT_TDATA_W'({COUNT_W'(res_count), res_pos, res_status});

  // cell chain: each cell sees its two neighbors; the ends get zeros
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [VALUE_W-1:0] left_data;
    logic [VALUE_W-1:0] right_data;

    if (k == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_inner_l
      assign left_data = cell_data[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_inner_r
      assign right_data = cell_data[k+1];
    end

    oal_cell u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .slot  (CMP_W'(k)),
      .count (cnt_ext),
      .left  (left_data),
      .right (right_data),
      .data  (cell_data[k]),
      .hit   (hits[k])
    );
  end

  // pad the hit vector up to a whole number of scan groups
  if (HIT_W > CAPACITY) begin : g_hit_pad
    assign hits[HIT_W-1:CAPACITY] = '0;
  end

  oal_scan u_scan (
    .clk   (clk),
    .rst   (rst),
    .clear (scan_clear),
    .step  (scan_step),
    .hits  (hits),
    .res   (scan)
  );

endmodule
